// ===== sv/vrst_pkg.sv =====
// Shared types, widths and codes of the scanout retrace timer.
// No dependencies; every other file of the block depends on this package.
package vrst_pkg;

    // Field widths
    localparam int TIME_BITS     = 64;
    localparam int PERIOD_BITS   = 32;
    localparam int ADDR_W        = 32;
    localparam int LINE_BITS     = 9;
    localparam int FIELD_BITS    = 16;
    localparam int INTERVAL_BITS = 16;
    localparam int OP_BITS       = 2;

    // Configuration port
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Retraces fired at most by one tick request
    localparam int MAX_CATCHUP = 4;
    localparam int CATCH_BITS  = $clog2(MAX_CATCHUP + 1);

    // Line estimate: product of time left and visible lines, divided by the period
    localparam int PROD_BITS = PERIOD_BITS + LINE_BITS;
    localparam int STEP_BITS = $clog2(LINE_BITS);

    // Request queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

    // Reset values of the registers
    localparam logic [PERIOD_BITS-1:0]   RST_PERIOD   = PERIOD_BITS'(781250);
    localparam logic [INTERVAL_BITS-1:0] RST_INTERVAL = INTERVAL_BITS'(1);
    localparam logic [LINE_BITS-1:0]     RST_LINES    = LINE_BITS'(240);

    // Request opcodes
    localparam logic [OP_BITS-1:0] OP_START  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SWAP   = 2'd2;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    // Register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PERIOD   = 3'd0,
        CFG_EVENT_EN = 3'd1,
        CFG_INTERVAL = 3'd2,
        CFG_BLANK    = 3'd3,
        CFG_LINES    = 3'd4
    } cfg_index_t;

    // Request class decided by the front end
    typedef enum logic [1:0] {
        KIND_START,
        KIND_TICK,
        KIND_SWAP,
        KIND_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [TIME_BITS-1:0]  now;
        logic [ADDR_W-1:0]     addr;
    } cmd_t;

    // Head of the request queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_out_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_LEFT,
        ST_RANGE,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    // Line divider request and response
    typedef struct packed {
        logic                   go;
        logic [PROD_BITS-1:0]   dividend;
        logic [PERIOD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [LINE_BITS-1:0] quot;
    } div_rsp_t;

    // One result record
    typedef struct packed {
        logic                 is_retrace;
        logic [ADDR_W-1:0]    shown_addr;
        logic                 event_fired;
        logic [ADDR_W-1:0]    current_addr;
        logic [ADDR_W-1:0]    upcoming_addr;
        logic [LINE_BITS-1:0] beam_line;
        logic                 field_parity;
        logic                 last;
    } result_t;

endpackage

// ===== sv/vrst_in_if.sv =====
// Request channel of the scanout retrace timer: valid, ready and the request fields.
// Depends on vrst_pkg for the field widths.
interface vrst_in_if;
    logic                           valid;
    logic                           ready;
    logic [vrst_pkg::OP_BITS-1:0]   op;
    logic [vrst_pkg::TIME_BITS-1:0] now_count;
    logic [vrst_pkg::ADDR_W-1:0]    buffer_addr;

    modport source (output valid, output op, output now_count, output buffer_addr,
                    input ready);
    modport sink (input valid, input op, input now_count, input buffer_addr,
                  output ready);
endinterface

// ===== sv/vrst_out_if.sv =====
// Result channel of the scanout retrace timer: valid, ready and the record fields.
// Depends on vrst_pkg for the field widths.
interface vrst_out_if;
    logic                           valid;
    logic                           ready;
    logic                           is_retrace;
    logic [vrst_pkg::ADDR_W-1:0]    shown_addr;
    logic                           event_fired;
    logic [vrst_pkg::ADDR_W-1:0]    current_addr;
    logic [vrst_pkg::ADDR_W-1:0]    upcoming_addr;
    logic [vrst_pkg::LINE_BITS-1:0] beam_line;
    logic                           field_parity;
    logic                           last;

    modport source (output valid, output is_retrace, output shown_addr,
                    output event_fired, output current_addr, output upcoming_addr,
                    output beam_line, output field_parity, output last, input ready);
    modport sink (input valid, input is_retrace, input shown_addr,
                  input event_fired, input current_addr, input upcoming_addr,
                  input beam_line, input field_parity, input last, output ready);
endinterface

// ===== sv/vrst_front.sv =====
// Front end: accepts requests, classifies the opcode and queues them for the back end.
// Depends on vrst_pkg and vrst_in_if.
module vrst_front (
    input  logic             clk,
    input  logic             rst_n,
    vrst_in_if.sink          item,
    input  logic             pop,
    output vrst_pkg::q_out_t q_out
);
    import vrst_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;
    cmd_t                incoming;
    logic                push;

    // Classify the request before it enters the queue.
    always_comb
    begin
        incoming.now  = item.now_count;
        incoming.addr = item.buffer_addr;
        unique case (item.op)
            OP_START:  incoming.kind = KIND_START;
            OP_TICK:   incoming.kind = KIND_TICK;
            OP_SWAP:   incoming.kind = KIND_SWAP;
            OP_UNUSED: incoming.kind = KIND_NOP;
            default:   incoming.kind = KIND_NOP;
        endcase
    end

    assign item.ready = (count_reg != (PTR_BITS+1)'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue entries hold payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign q_out.valid = (count_reg != '0);
    assign q_out.cmd   = mem_reg[rd_ptr_reg];

endmodule

// ===== sv/vrst_div.sv =====
// Bit-serial restoring divider for the beam line estimate, one quotient bit a cycle.
// Depends on vrst_pkg; the quotient is known to fit LINE_BITS bits.
module vrst_div (
    input  logic               clk,
    input  logic               rst_n,
    input  vrst_pkg::div_req_t req,
    output vrst_pkg::div_rsp_t rsp
);
    import vrst_pkg::*;

    logic [PROD_BITS-1:0] rem_reg, rem_next;
    logic [PROD_BITS-1:0] sh_reg, sh_next;
    logic [LINE_BITS-1:0] quot_reg, quot_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 fits;

    assign fits = (rem_reg >= sh_reg);

    // Load on go, then subtract the shifted divisor where it fits.
    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            rem_next  = req.dividend;
            sh_next   = PROD_BITS'(req.divisor) << (LINE_BITS - 1);
            quot_next = '0;
            step_next = STEP_BITS'(LINE_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - sh_reg;
            end
            quot_next = {quot_reg[LINE_BITS-2:0], fits};
            sh_next   = sh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== sv/vrst_back.sv =====
// Back end: configuration registers, scanout state, retrace sequencer and output register.
// Depends on vrst_pkg and vrst_out_if; drives the line divider vrst_div.
module vrst_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [vrst_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [vrst_pkg::CFG_DATA_BITS-1:0]  wr_data,
    input  vrst_pkg::q_out_t                    q_out,
    output logic                                pop,
    output vrst_pkg::div_req_t                  div_req,
    input  vrst_pkg::div_rsp_t                  div_rsp,
    vrst_out_if.source                          result
);
    import vrst_pkg::*;

    // Configuration
    logic [PERIOD_BITS-1:0]   period_reg, period_next;
    logic                     event_en_reg, event_en_next;
    logic [INTERVAL_BITS-1:0] interval_reg, interval_next;
    logic                     blank_reg, blank_next;
    logic [LINE_BITS-1:0]     lines_reg, lines_next;

    // Scanout state
    logic                     running_reg, running_next;
    logic [TIME_BITS-1:0]     deadline_reg, deadline_next;
    logic [ADDR_W-1:0]        current_reg, current_next;
    logic [ADDR_W-1:0]        armed_reg, armed_next;
    logic [FIELD_BITS-1:0]    field_reg, field_next;
    logic [INTERVAL_BITS-1:0] countdown_reg, countdown_next;

    // Sequencer
    back_state_t              state_reg, state_next;
    logic [CATCH_BITS-1:0]    guard_reg, guard_next;
    logic                     div_go_reg, div_go_next;
    logic                     out_valid_reg, out_valid_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [TIME_BITS-1:0]     left_reg, left_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [PROD_BITS-1:0]     dividend_reg, dividend_next;
    result_t                  out_reg, out_next;

    // Derived values
    logic                     slot_free;
    logic                     due;
    logic [ADDR_W-1:0]        cur_after;
    logic [FIELD_BITS-1:0]    field_after;
    logic [INTERVAL_BITS-1:0] cd_dec;
    logic                     fire;
    logic [INTERVAL_BITS-1:0] wr_interval;

    assign slot_free   = !out_valid_reg || result.ready;
    assign due         = (cmd_reg.now >= deadline_reg);
    assign cur_after   = (armed_reg != '0) ? armed_reg : current_reg;
    assign field_after = field_reg + FIELD_BITS'(1);
    assign cd_dec      = countdown_reg - INTERVAL_BITS'(1);
    assign fire        = event_en_reg && (cd_dec == '0);
    assign wr_interval = (wr_data[INTERVAL_BITS-1:0] == '0) ? INTERVAL_BITS'(1)
                                                            : wr_data[INTERVAL_BITS-1:0];

    // Sequencer next state, state updates and record assembly.
    always_comb
    begin
        period_next    = period_reg;
        event_en_next  = event_en_reg;
        interval_next  = interval_reg;
        blank_next     = blank_reg;
        lines_next     = lines_reg;
        running_next   = running_reg;
        deadline_next  = deadline_reg;
        current_next   = current_reg;
        armed_next     = armed_reg;
        field_next     = field_reg;
        countdown_next = countdown_reg;
        state_next     = state_reg;
        guard_next     = guard_reg;
        div_go_next    = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        cmd_next       = cmd_reg;
        left_next      = left_reg;
        line_next      = line_reg;
        dividend_next  = dividend_reg;
        out_next       = out_reg;
        pop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_out.valid)
                begin
                    pop        = 1'b1;
                    cmd_next   = q_out.cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_LEFT;
                case (cmd_reg.kind)
                    KIND_START:
                    begin
                        if (!running_reg)
                        begin
                            running_next  = 1'b1;
                            deadline_next = cmd_reg.now + TIME_BITS'(period_reg);
                        end
                    end
                    KIND_SWAP:
                    begin
                        armed_next = cmd_reg.addr;
                    end
                    KIND_TICK:
                    begin
                        if (running_reg)
                        begin
                            guard_next = '0;
                            state_next = ST_CHECK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CHECK:
            begin
                // Fire one owed retrace per cycle while the output slot is free, up to the catch-up limit.
                if (due && (guard_reg != CATCH_BITS'(MAX_CATCHUP)))
                begin
                    if (slot_free)
                    begin
                        guard_next    = guard_reg + CATCH_BITS'(1);
                        deadline_next = deadline_reg + TIME_BITS'(period_reg);
                        field_next    = field_after;
                        current_next  = cur_after;
                        armed_next    = '0;
                        if (event_en_reg)
                        begin
                            countdown_next = fire ? interval_reg : cd_dec;
                        end
                        out_valid_next         = 1'b1;
                        out_next.is_retrace    = 1'b1;
                        out_next.shown_addr    = blank_reg ? '0 : cur_after;
                        out_next.event_fired   = fire;
                        out_next.current_addr  = cur_after;
                        out_next.upcoming_addr = cur_after;
                        out_next.beam_line     = '0;
                        out_next.field_parity  = field_after[0];
                        out_next.last          = 1'b0;
                    end
                end
                else
                begin
                    // Still behind after the limit: restart the deadline from now.
                    if (due)
                    begin
                        deadline_next = cmd_reg.now + TIME_BITS'(period_reg);
                    end
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:
            begin
                left_next  = (deadline_reg > cmd_reg.now) ? deadline_reg - cmd_reg.now : '0;
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                if ((period_reg == '0) || (left_reg >= TIME_BITS'(period_reg)))
                begin
                    line_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    dividend_next = PROD_BITS'(left_reg[PERIOD_BITS-1:0])
                                    * PROD_BITS'(lines_reg);
                    div_go_next   = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    line_next  = lines_reg - div_rsp.quot;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.is_retrace    = 1'b0;
                    out_next.shown_addr    = '0;
                    out_next.event_fired   = 1'b0;
                    out_next.current_addr  = current_reg;
                    out_next.upcoming_addr = cur_after;
                    out_next.beam_line     = line_reg;
                    out_next.field_parity  = field_reg[0];
                    out_next.last          = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes must arrive only while no request is in flight; the block itself does not enforce it.
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_PERIOD:   period_next = wr_data[PERIOD_BITS-1:0];
                CFG_EVENT_EN: event_en_next = wr_data[0];
                CFG_INTERVAL:
                begin
                    interval_next  = wr_interval;
                    countdown_next = wr_interval;
                end
                CFG_BLANK:    blank_next = wr_data[0];
                CFG_LINES:    lines_next = wr_data[LINE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control, configuration and scanout state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= RST_PERIOD;
            event_en_reg  <= 1'b0;
            interval_reg  <= RST_INTERVAL;
            blank_reg     <= 1'b0;
            lines_reg     <= RST_LINES;
            running_reg   <= 1'b0;
            deadline_reg  <= '0;
            current_reg   <= '0;
            armed_reg     <= '0;
            field_reg     <= '0;
            countdown_reg <= INTERVAL_BITS'(1);
            state_reg     <= ST_IDLE;
            guard_reg     <= '0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            period_reg    <= period_next;
            event_en_reg  <= event_en_next;
            interval_reg  <= interval_next;
            blank_reg     <= blank_next;
            lines_reg     <= lines_next;
            running_reg   <= running_next;
            deadline_reg  <= deadline_next;
            current_reg   <= current_next;
            armed_reg     <= armed_next;
            field_reg     <= field_next;
            countdown_reg <= countdown_next;
            state_reg     <= state_next;
            guard_reg     <= guard_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        left_reg     <= left_next;
        line_reg     <= line_next;
        dividend_reg <= dividend_next;
        out_reg      <= out_next;
    end

    assign div_req.go       = div_go_reg;
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = period_reg;

    assign result.valid         = out_valid_reg;
    assign result.is_retrace    = out_reg.is_retrace;
    assign result.shown_addr    = out_reg.shown_addr;
    assign result.event_fired   = out_reg.event_fired;
    assign result.current_addr  = out_reg.current_addr;
    assign result.upcoming_addr = out_reg.upcoming_addr;
    assign result.beam_line     = out_reg.beam_line;
    assign result.field_parity  = out_reg.field_parity;
    assign result.last          = out_reg.last;

`ifndef SYNTHESIS
    // The divider quotient never exceeds the visible line count.
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (div_rsp.quot <= lines_reg))
        else $error("line divider quotient above visible lines");

    // A retrace record is never the last one and a status record always is.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.is_retrace != out_reg.last))
        else $error("record kind and last flag disagree");

    // One tick fires no more retraces than the catch-up limit.
    a_guard: assert property (@(posedge clk) disable iff (!rst_n)
        guard_reg <= CATCH_BITS'(MAX_CATCHUP))
        else $error("catch-up count above limit");

    // Once started, the timer keeps running.
    a_running: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |=> running_reg)
        else $error("running flag dropped");

    // The event countdown never rests at zero.
    a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        countdown_reg != '0)
        else $error("event countdown at zero");
`endif

endmodule

// ===== sv/video_retrace_scanout_timer_core.sv =====
// Top level of the scanout retrace timer: request queue, sequencer and line divider.
// Depends on vrst_pkg, vrst_in_if, vrst_out_if, vrst_front, vrst_div and vrst_back.
//
// A start request arms the first retrace one period after its counter time, a swap
// request arms the next framebuffer address, and a tick request fires every retrace
// that is due (at most four) and then reports status; every request ends with one
// status record flagged last. The front end holds up to two requests while the back
// end works, so the request side keeps flowing while a record waits to be taken.
// The back end handles one request at a time: a start, swap or ignored request goes
// through the exec, left, range and emit states; a tick on a running timer adds the
// check state, which fires each due retrace; a beam line estimate that needs the
// divide also waits in the div state on the bit-serial divider, which produces one
// of the nine quotient bits per cycle. Every record leaves through a single output
// register, so a stalled result side holds the sequencer.
module video_retrace_scanout_timer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [vrst_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [vrst_pkg::CFG_DATA_BITS-1:0]  wr_data,
    vrst_in_if.sink                             item,
    vrst_out_if.source                          result
);
    import vrst_pkg::*;

    q_out_t   q_out;
    logic     pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Request acceptance and queue.
    vrst_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .pop   (pop),
        .q_out (q_out)
    );

    // Beam line divider.
    vrst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Retrace sequencer and result register.
    vrst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_out    (q_out),
        .pop      (pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .result   (result)
    );

endmodule

// ===== tb/sv/video_retrace_scanout_timer_core_tb.sv =====
// Self-checking testbench for the scanout retrace timer: a directed table of requests,
// then randomized requests over several register settings, checked against a predictor.
// Depends on vrst_pkg, vrst_in_if, vrst_out_if and video_retrace_scanout_timer_core.
module video_retrace_scanout_timer_core_tb;
    import vrst_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SETTLE      = 40;
    localparam logic [63:0] FIELD_T     = 64'(RST_PERIOD);
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    // One row of the directed table; the typed fields are used only when typed is set.
    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [TIME_BITS-1:0] now;
        logic [ADDR_W-1:0]    addr;
        logic                 typed;
        logic [ADDR_W-1:0]    cur;
        logic [ADDR_W-1:0]    up;
        logic [LINE_BITS-1:0] beam;
    } step_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      wr_en;
    logic [CFG_INDEX_BITS-1:0] wr_index;
    logic [CFG_DATA_BITS-1:0]  wr_data;

    vrst_in_if  item_ch ();
    vrst_out_if result_ch ();

    video_retrace_scanout_timer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    // Registers as the predictor sees them.
    logic [PERIOD_BITS-1:0]   reg_period;
    logic                     reg_event_en;
    logic [INTERVAL_BITS-1:0] reg_interval;
    logic                     reg_blank;
    logic [LINE_BITS-1:0]     reg_lines;

    // Timer state as the predictor sees it.
    logic                     track_running;
    logic [TIME_BITS-1:0]     track_deadline;
    logic [ADDR_W-1:0]        track_current;
    logic [ADDR_W-1:0]        track_armed;
    logic [FIELD_BITS-1:0]    track_fields;
    logic [INTERVAL_BITS-1:0] track_countdown;

    result_t pending_records[$];

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int          hold_left;
    int          cycles;
    int          mismatches;
    int          requests_sent;
    int          records_seen;
    int          retraces_seen;
    int          events_seen;
    int          settings_used;

    step_row_t   steps [21];

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at record %0d: %s", records_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Beam line estimate from the time left until the next retrace.
    function automatic logic [LINE_BITS-1:0] line_estimate(input logic [TIME_BITS-1:0] now);
        logic [63:0] left;
        left = (track_deadline > now) ? track_deadline - now : 64'd0;
        if (reg_period == '0 || left >= 64'(reg_period))
            return '0;
        return LINE_BITS'(64'(reg_lines) - (left * 64'(reg_lines)) / 64'(reg_period));
    endfunction

    // Record built from the predicted state right now.
    function automatic result_t snapshot(input logic retr, input logic [ADDR_W-1:0] shown,
                                         input logic fired, input logic [LINE_BITS-1:0] line,
                                         input logic fin);
        result_t r;
        r.is_retrace    = retr;
        r.shown_addr    = shown;
        r.event_fired   = fired;
        r.current_addr  = track_current;
        r.upcoming_addr = (track_armed != '0) ? track_armed : track_current;
        r.beam_line     = line;
        r.field_parity  = track_fields[0];
        r.last          = fin;
        return r;
    endfunction

    // One retrace: count the field, promote the armed buffer, maybe fire the event.
    task automatic retrace_step();
        logic [ADDR_W-1:0] shown;
        logic              fired;
        fired = 1'b0;
        track_fields = track_fields + 1'b1;
        if (track_armed != '0)
        begin
            track_current = track_armed;
            track_armed   = '0;
        end
        shown = reg_blank ? '0 : track_current;
        if (reg_event_en)
        begin
            track_countdown = track_countdown - 1'b1;
            if (track_countdown == '0)
            begin
                track_countdown = reg_interval;
                fired           = 1'b1;
            end
        end
        pending_records.push_back(snapshot(1'b1, shown, fired, '0, 1'b0));
    endtask

    // Predicts every record of one accepted request and queues them.
    task automatic forecast(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] now,
                            input logic [ADDR_W-1:0] addr);
        int guard;
        guard = MAX_CATCHUP;
        case (op)
            OP_START:
                if (!track_running)
                begin
                    track_running  = 1'b1;
                    track_deadline = now + 64'(reg_period);
                end
            OP_TICK:
                if (track_running)
                begin
                    while (now >= track_deadline && guard > 0)
                    begin
                        guard--;
                        track_deadline = track_deadline + 64'(reg_period);
                        retrace_step();
                    end
                    if (now >= track_deadline)
                        track_deadline = now + 64'(reg_period);
                end
            OP_SWAP:
                track_armed = addr;
            default:
                ;
        endcase
        pending_records.push_back(snapshot(1'b0, '0, 1'b0, line_estimate(now), 1'b1));
    endtask

    // Writes one register at the next edge and mirrors it into the predictor.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_PERIOD:   reg_period   = val[PERIOD_BITS-1:0];
            CFG_EVENT_EN: reg_event_en = val[0];
            CFG_INTERVAL:
            begin
                reg_interval    = (val[INTERVAL_BITS-1:0] == '0) ? INTERVAL_BITS'(1)
                                                                 : val[INTERVAL_BITS-1:0];
                track_countdown = reg_interval;
            end
            CFG_BLANK:    reg_blank    = val[0];
            CFG_LINES:    reg_lines    = val[LINE_BITS-1:0];
            default:      ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_records.size() != 0)
            @(posedge clk);
    endtask

    // New register setting, applied only once the block has gone quiet.
    task automatic apply_settings(input logic [31:0] period, input logic ev_en,
                                  input logic [15:0] interval, input logic blank,
                                  input logic [8:0] lines);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        write_reg(CFG_PERIOD, period);
        write_reg(CFG_EVENT_EN, 32'(ev_en));
        write_reg(CFG_INTERVAL, 32'(interval));
        write_reg(CFG_BLANK, 32'(blank));
        write_reg(CFG_LINES, 32'(lines));
        wr_en <= 1'b0;
        settings_used++;
    endtask

    // Offers one request after a random gap, waits for it to be taken, then predicts it.
    task automatic send_request(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] now,
                                input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.op          <= op;
        item_ch.now_count   <= now;
        item_ch.buffer_addr <= addr;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        forecast(op, now, addr);
        requests_sent++;
    endtask

    // Tick time placed around the predicted deadline, with some noise.
    function automatic logic [TIME_BITS-1:0] tick_time();
        logic [63:0] per;
        per = 64'(reg_period);
        case ($urandom_range(9))
            0, 1, 2:
                return track_deadline -
                       ((per > 1) ? 64'($urandom_range(reg_period - 1, 1)) : 64'd1);
            3:
                return track_deadline;
            4, 5, 6:
                return track_deadline + per * 64'($urandom_range(3)) +
                       ((per > 1) ? 64'($urandom_range(reg_period - 1, 0)) : 64'd0);
            7:
                return track_deadline + per * 64'($urandom_range(8, 4));
            8:
                return track_deadline + 64'd1;
            default:
                return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly ticks and swaps in a plausible order; starts, the unused code and raw times as noise.
    task automatic send_random(input int count);
        int unsigned       roll;
        logic [OP_BITS-1:0] op;
        logic [63:0]       now;
        logic [31:0]       addr;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            now  = {$urandom, $urandom};
            addr = $urandom;
            if (roll < 62)
            begin
                op  = OP_TICK;
                now = tick_time();
            end
            else if (roll < 76)
            begin
                op = OP_SWAP;
                case ($urandom_range(5))
                    0:       addr = '0;
                    1:       addr = '1;
                    default: ;
                endcase
            end
            else if (roll < 84)
                op = OP_START;
            else if (roll < 90)
                op = OP_UNUSED;
            else
                op = OP_TICK;
            send_request(op, now, addr);
        end
    endtask

    // Result side: check each taken record, then choose ready for the next cycle.
    always @(posedge clk)
    begin : result_side
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_records.size() == 0)
                report_mismatch("record arrived with no request pending");
            else
            begin
                want = pending_records.pop_front();
                check_field("is_retrace", 64'(result_ch.is_retrace), 64'(want.is_retrace));
                check_field("shown_addr", 64'(result_ch.shown_addr), 64'(want.shown_addr));
                check_field("event_fired", 64'(result_ch.event_fired), 64'(want.event_fired));
                check_field("current_addr", 64'(result_ch.current_addr),
                            64'(want.current_addr));
                check_field("upcoming_addr", 64'(result_ch.upcoming_addr),
                            64'(want.upcoming_addr));
                check_field("beam_line", 64'(result_ch.beam_line), 64'(want.beam_line));
                check_field("field_parity", 64'(result_ch.field_parity),
                            64'(want.field_parity));
                check_field("last", 64'(result_ch.last), 64'(want.last));
            end
            records_seen++;
            if (result_ch.is_retrace)
                retraces_seen++;
            if (result_ch.event_fired)
                events_seen++;
        end
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Watchdog expired after %0d cycles, %0d records outstanding",
                 cycles, pending_records.size());
        $display("Verification failed");
        $finish;
    end

    // Stimulus.
    initial
    begin : stimulus
        result_t typed_rec;

        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = CFG_PERIOD;
        wr_data             = '0;
        item_ch.valid       = 1'b0;
        item_ch.op          = OP_START;
        item_ch.now_count   = '0;
        item_ch.buffer_addr = '0;
        result_ch.ready     = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        hold_left           = 0;
        mismatches          = 0;
        requests_sent       = 0;
        records_seen        = 0;
        retraces_seen       = 0;
        events_seen         = 0;
        settings_used       = 1;

        reg_period      = RST_PERIOD;
        reg_event_en    = 1'b0;
        reg_interval    = RST_INTERVAL;
        reg_blank       = 1'b0;
        reg_lines       = RST_LINES;
        track_running   = 1'b0;
        track_deadline  = '0;
        track_current   = '0;
        track_armed     = '0;
        track_fields    = '0;
        track_countdown = INTERVAL_BITS'(1);

        // Directed requests under the reset settings; the first rows have known status.
        steps = '{
            '{OP_TICK,   64'd0,      32'd0,          1'b1, 32'd0, 32'd0,          9'd240},
            '{OP_UNUSED, ALL_ONES,   32'd0,          1'b1, 32'd0, 32'd0,          9'd240},
            '{OP_SWAP,   64'd0,      32'hFFFF_FFFF,  1'b1, 32'd0, 32'hFFFF_FFFF,  9'd240},
            '{OP_START,  64'd0,      32'd0,          1'b1, 32'd0, 32'hFFFF_FFFF,  9'd0},
            '{OP_START,  64'd5,      32'd0,          1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   FIELD_T - 1, 32'd0,         1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   FIELD_T,    32'd0,          1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_SWAP,   64'd0,      32'd1,          1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_SWAP,   64'd0,      32'd0,          1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_SWAP,   64'd0,      32'h1234_5678,  1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   FIELD_T * 2 + FIELD_T / 2, 32'd0, 1'b0, 32'd0, 32'd0,    9'd0},
            '{OP_TICK,   FIELD_T * 3, 32'd0,         1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   FIELD_T * 9, 32'd0,         1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   FIELD_T * 10 - 1, 32'd0,    1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   ALL_ONES,   32'd0,          1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   64'd0,      32'd0,          1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   64'h8000_0000_0000_0000, 32'd0, 1'b0, 32'd0, 32'd0,      9'd0},
            '{OP_UNUSED, 64'd0,      32'hFFFF_FFFF,  1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_SWAP,   64'd0,      32'hAAAA_AAAA,  1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_SWAP,   64'd0,      32'h5555_5555,  1'b0, 32'd0, 32'd0,          9'd0},
            '{OP_TICK,   ALL_ONES,   32'd0,          1'b0, 32'd0, 32'd0,          9'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            send_request(steps[i].op, steps[i].now, steps[i].addr);
            if (steps[i].typed)
            begin
                // Rows with a typed status replace the predicted one.
                typed_rec               = pending_records.pop_back();
                typed_rec.is_retrace    = 1'b0;
                typed_rec.shown_addr    = '0;
                typed_rec.event_fired   = 1'b0;
                typed_rec.current_addr  = steps[i].cur;
                typed_rec.upcoming_addr = steps[i].up;
                typed_rec.beam_line     = steps[i].beam;
                typed_rec.field_parity  = 1'b0;
                typed_rec.last          = 1'b1;
                pending_records.push_back(typed_rec);
            end
        end
        item_ch.valid <= 1'b0;

        // Short period with events every third retrace, no idling.
        apply_settings(32'd1000, 1'b1, 16'd3, 1'b0, 9'd240);
        send_random(35);
        item_ch.valid <= 1'b0;

        // Minimum period, blanked output, no visible lines; sender idles.
        apply_settings(32'd1, 1'b1, 16'd1, 1'b1, 9'd0);
        send_idle_pct = 58;
        stall_pct     = 0;
        send_random(35);
        item_ch.valid <= 1'b0;

        // Maximum period, widest interval and a line count of 288; receiver stalls.
        apply_settings(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0, 9'd288);
        send_idle_pct = 0;
        stall_pct     = 58;
        send_random(35);
        item_ch.valid <= 1'b0;

        // Zero period and a zero interval that must read back as one; both sides idle.
        apply_settings(32'd0, 1'b1, 16'd0, 1'b0, 9'd288);
        send_idle_pct = 32;
        stall_pct     = 32;
        send_random(35);
        item_ch.valid <= 1'b0;

        // Long receiver hold-off while requests keep coming, then a full drain.
        apply_settings(32'd50000, 1'b1, 16'd2, 1'b0, 9'd200);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 400;
        send_random(20);
        item_ch.valid <= 1'b0;
        wait_drained();
        send_idle_pct = 32;
        stall_pct     = 32;
        send_random(15);
        item_ch.valid <= 1'b0;

        // Back to the reset period and line count with events off and blanking on; both sides idle often.
        apply_settings(RST_PERIOD, 1'b0, 16'd5, 1'b1, RST_LINES);
        send_idle_pct = 58;
        stall_pct     = 58;
        send_random(35);
        item_ch.valid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d requests and %0d records (%0d retraces, %0d events)",
                 requests_sent, records_seen, retraces_seen, events_seen);
        $display("across %0d register settings with idle and stall phases; %0d mismatches.",
                 settings_used, mismatches);
        if (mismatches == 0 && pending_records.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
